FILE: hdl/morse_character_keyer_macros.svh
// ----------------------------------------------------------------------------
// morse_character_keyer_macros.svh
// Assertion helpers used by the keyer back end (mck_back).
// ----------------------------------------------------------------------------
`ifndef MORSE_CHARACTER_KEYER_MACROS_SVH
`define MORSE_CHARACTER_KEYER_MACROS_SVH

// condition must never hold outside reset
`define MCK_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("keyer check failed: forbidden condition");

// same-cycle implication
`define MCK_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyer check failed: implication");

// next-cycle implication
`define MCK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyer check failed: next-cycle implication");

`endif

FILE: hdl/mck_pkg.sv
// ----------------------------------------------------------------------------
// mck_pkg
// Shared types, constants and the Morse pattern table for the keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

  localparam logic [13:0] DUR_MAX = 14'h3FFF;

  // configuration register indexes
  localparam logic [1:0] REG_DOT_MS        = 2'd0;
  localparam logic [1:0] REG_DASH_MS       = 2'd1;
  localparam logic [1:0] REG_CHAR_PAUSE_MS = 2'd2;

  localparam logic [10:0] DOT_MS_RST        = 11'd100;
  localparam logic [11:0] DASH_MS_RST       = 12'd300;
  localparam logic [13:0] CHAR_PAUSE_MS_RST = 14'd300;

  typedef struct packed {
    logic [10:0] dot_ms;
    logic [11:0] dash_ms;
    logic [13:0] char_pause_ms;
  } cfg_t;

  // what the back end has to send for one character
  typedef enum logic [1:0] {
    JOB_PAUSE,
    JOB_WORD_SPACE,
    JOB_PATTERN
  } job_kind_t;

  // pattern is left aligned: element i sits at bit 5-i, 1 = dash
  typedef struct packed {
    logic       known;
    logic [2:0] len;
    logic [5:0] pat;
  } morse_pat_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [2:0] len;
    logic [5:0] pat;
  } job_t;

  // Morse lookup; lower case folded to upper case
  function automatic morse_pat_t morse_lookup(input logic [7:0] c);
    logic [7:0] uc;
    morse_pat_t r;
    uc = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      uc = c - 8'h20;
    end
    case (uc)
      8'h41: r = {1'b1, 3'd2, 6'b010000}; // A
      8'h42: r = {1'b1, 3'd4, 6'b100000}; // B
      8'h43: r = {1'b1, 3'd4, 6'b101000}; // C
      8'h44: r = {1'b1, 3'd3, 6'b100000}; // D
      8'h45: r = {1'b1, 3'd1, 6'b000000}; // E
      8'h46: r = {1'b1, 3'd4, 6'b001000}; // F
      8'h47: r = {1'b1, 3'd3, 6'b110000}; // G
      8'h48: r = {1'b1, 3'd4, 6'b000000}; // H
      8'h49: r = {1'b1, 3'd2, 6'b000000}; // I
      8'h4A: r = {1'b1, 3'd4, 6'b011100}; // J
      8'h4B: r = {1'b1, 3'd3, 6'b101000}; // K
      8'h4C: r = {1'b1, 3'd4, 6'b010000}; // L
      8'h4D: r = {1'b1, 3'd2, 6'b110000}; // M
      8'h4E: r = {1'b1, 3'd2, 6'b100000}; // N
      8'h4F: r = {1'b1, 3'd3, 6'b111000}; // O
      8'h50: r = {1'b1, 3'd4, 6'b011000}; // P
      8'h51: r = {1'b1, 3'd4, 6'b110100}; // Q
      8'h52: r = {1'b1, 3'd3, 6'b010000}; // R
      8'h53: r = {1'b1, 3'd3, 6'b000000}; // S
      8'h54: r = {1'b1, 3'd1, 6'b100000}; // T
      8'h55: r = {1'b1, 3'd3, 6'b001000}; // U
      8'h56: r = {1'b1, 3'd4, 6'b000100}; // V
      8'h57: r = {1'b1, 3'd3, 6'b011000}; // W
      8'h58: r = {1'b1, 3'd4, 6'b100100}; // X
      8'h59: r = {1'b1, 3'd4, 6'b101100}; // Y
      8'h5A: r = {1'b1, 3'd4, 6'b110000}; // Z
      8'h30: r = {1'b1, 3'd5, 6'b111110}; // 0
      8'h31: r = {1'b1, 3'd5, 6'b011110}; // 1
      8'h32: r = {1'b1, 3'd5, 6'b001110}; // 2
      8'h33: r = {1'b1, 3'd5, 6'b000110}; // 3
      8'h34: r = {1'b1, 3'd5, 6'b000010}; // 4
      8'h35: r = {1'b1, 3'd5, 6'b000000}; // 5
      8'h36: r = {1'b1, 3'd5, 6'b100000}; // 6
      8'h37: r = {1'b1, 3'd5, 6'b110000}; // 7
      8'h38: r = {1'b1, 3'd5, 6'b111000}; // 8
      8'h39: r = {1'b1, 3'd5, 6'b111100}; // 9
      8'h2E: r = {1'b1, 3'd6, 6'b010101}; // period
      8'h2C: r = {1'b1, 3'd6, 6'b110011}; // comma
      8'h3F: r = {1'b1, 3'd6, 6'b001100}; // question mark
      8'h2F: r = {1'b1, 3'd5, 6'b100100}; // slash
      8'h3D: r = {1'b1, 3'd5, 6'b100010}; // equals
      default: r = {1'b0, 3'd0, 6'b000000};
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/mck_front.sv
// ----------------------------------------------------------------------------
// mck_front
// Classifies text bytes into keying jobs and tracks word-space state.
// ----------------------------------------------------------------------------
module mck_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [7:0]    char_code,
  input  logic          job_full,
  output logic          job_push,
  output mck_pkg::job_t job
);

  logic               gap_sent;
  logic               is_space;
  mck_pkg::morse_pat_t lk;

  // classification
  always_comb begin
    is_space = (char_code <= 8'h20) || (char_code >= 8'h7F);
    lk       = mck_pkg::morse_lookup(char_code);
    job.len  = lk.len;
    job.pat  = lk.pat;
    if (is_space) begin
      job.kind = gap_sent ? mck_pkg::JOB_PAUSE : mck_pkg::JOB_WORD_SPACE;
    end else if (lk.known) begin
      job.kind = mck_pkg::JOB_PATTERN;
    end else begin
      job.kind = mck_pkg::JOB_PAUSE;
    end
  end

  assign job_push = push && !job_full;

  // word-space tracking: set by a transferred space, cleared by a transferred known character
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_sent <= 1'b0;
    end else if (job_push) begin
      if (is_space) begin
        gap_sent <= 1'b1;
      end else if (lk.known) begin
        gap_sent <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/mck_job_fifo.sv
// ----------------------------------------------------------------------------
// mck_job_fifo
// Two-entry queue of keying jobs between front and back end.
// ----------------------------------------------------------------------------
module mck_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  mck_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_valid,
  output mck_pkg::job_t rd_job
);

  mck_pkg::job_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_job   = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      if (wr_en && !rd_en) begin
        count <= count + 2'd1;
      end else if (rd_en && !wr_en) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: hdl/mck_back.sv
// ----------------------------------------------------------------------------
// mck_back
// Segment sequencer: expands one job into keying segments, one per cycle while the output is popped or empty.
// ----------------------------------------------------------------------------
`include "morse_character_keyer_macros.svh"

module mck_back (
  input  logic          clk,
  input  logic          rst,
  input  mck_pkg::cfg_t cfg,
  input  logic          job_avail,
  input  mck_pkg::job_t job_head,
  output logic          job_take,
  output logic          empty,
  input  logic          pop,
  output logic          tone_on,
  output logic [13:0]   duration_ms,
  output logic          last
);

  mck_pkg::job_t job;
  logic          job_valid;
  logic [3:0]    seg_idx;
  logic          out_valid;

  logic [3:0]    n_body;
  logic          pop_ok;
  logic          adv;
  logic          seg_last;
  logic          seg_tone;
  logic [13:0]   seg_dur;
  logic [14:0]   ws_sum;
  logic [13:0]   ws_dur;
  logic [2:0]    elem_idx;

  assign pop_ok = pop && out_valid;
  assign empty  = !out_valid;
  assign adv    = job_valid && (!out_valid || pop_ok);

  // segment count before the closing pause
  always_comb begin
    unique case (job.kind)
      mck_pkg::JOB_WORD_SPACE: n_body = 4'd1;
      mck_pkg::JOB_PATTERN:    n_body = {job.len, 1'b0} - 4'd1;
      default:                 n_body = 4'd0;
    endcase
  end

  // word-space silence, saturated
  assign ws_sum = {4'd0, cfg.dot_ms} + {1'b0, cfg.char_pause_ms};
  assign ws_dur = ws_sum[14] ? mck_pkg::DUR_MAX : ws_sum[13:0];

  // current segment
  always_comb begin
    elem_idx = seg_idx[3:1];
    seg_last = (seg_idx == n_body);
    seg_tone = 1'b0;
    seg_dur  = cfg.char_pause_ms;
    if (!seg_last) begin
      if (job.kind == mck_pkg::JOB_WORD_SPACE) begin
        seg_dur = ws_dur;
      end else if (seg_idx[0]) begin
        seg_dur = {3'd0, cfg.dot_ms};
      end else begin
        seg_tone = 1'b1;
        seg_dur  = job.pat[3'd5 - elem_idx] ? {2'd0, cfg.dash_ms} : {3'd0, cfg.dot_ms};
      end
    end
  end

  assign job_take = job_avail && (!job_valid || (adv && seg_last));

  // job register and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      seg_idx   <= 4'd0;
    end else if (job_take) begin
      job_valid <= 1'b1;
      seg_idx   <= 4'd0;
    end else if (adv) begin
      seg_idx <= seg_idx + 4'd1;
      if (seg_last) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      job <= job_head;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (pop_ok) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tone_on     <= seg_tone;
      duration_ms <= seg_dur;
      last        <= seg_last;
    end
  end

  `MCK_ASSERT_NEVER(a_idx_in_range, clk, rst, job_valid && (seg_idx > n_body))
  `MCK_ASSERT_NEXT(a_take_restarts, clk, rst, job_take, job_valid && (seg_idx == 4'd0))
  `MCK_ASSERT_NEXT(a_no_drop, clk, rst, out_valid && !pop, out_valid)
  `MCK_ASSERT_IMPLIES(a_take_when_free, clk, rst, job_take && job_valid, adv && seg_last)

endmodule

FILE: hdl/morse_character_keyer.sv
// A character passes through the job queue, the job register and the output register before its first segment shows.
// Throughput: one segment per cycle while segments are popped; a character is 1 to 12 segments,
// and the segment sequencer in the back end sets this rate.
// A two-entry job queue lets new characters be taken while segments are still sent.
// Reset (rst, synchronous) empties the queue and output, clears the word-space flag and
// loads dot 100 ms, dash 300 ms and character pause 300 ms.
// ----------------------------------------------------------------------------
// morse_character_keyer
// Text byte to Morse keying segments with Farnsworth character spacing.
// ----------------------------------------------------------------------------
module morse_character_keyer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_code,
  output logic        empty,
  input  logic        pop,
  output logic        tone_on,
  output logic [13:0] duration_ms,
  output logic        last
);

  mck_pkg::cfg_t cfg;
  mck_pkg::job_t front_job;
  mck_pkg::job_t head_job;
  logic          job_push;
  logic          job_take;
  logic          job_avail;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dot_ms        <= mck_pkg::DOT_MS_RST;
      cfg.dash_ms       <= mck_pkg::DASH_MS_RST;
      cfg.char_pause_ms <= mck_pkg::CHAR_PAUSE_MS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mck_pkg::REG_DOT_MS:        cfg.dot_ms        <= cfg_data[10:0];
        mck_pkg::REG_DASH_MS:       cfg.dash_ms       <= cfg_data[11:0];
        mck_pkg::REG_CHAR_PAUSE_MS: cfg.char_pause_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  mck_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .char_code (char_code),
    .job_full  (full),
    .job_push  (job_push),
    .job       (front_job)
  );

  mck_job_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (job_push),
    .wr_job   (front_job),
    .full     (full),
    .rd_en    (job_take),
    .rd_valid (job_avail),
    .rd_job   (head_job)
  );

  mck_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .job_avail   (job_avail),
    .job_head    (head_job),
    .job_take    (job_take),
    .empty       (empty),
    .pop         (pop),
    .tone_on     (tone_on),
    .duration_ms (duration_ms),
    .last        (last)
  );

endmodule

FILE: test/tb_morse_character_keyer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_morse_character_keyer
// Self-checking bench: text bytes go in through the push/full queue port,
// keying segments come back through empty/pop. A local Morse encoder predicts
// every segment, and the bench walks several register settings from minimum
// to saturating values, with random stalls on both sides outside one steady phase.
// ----------------------------------------------------------------------------
module tb_morse_character_keyer;

  localparam int          STALL_LIMIT = 2000;
  localparam int          SETTLE      = 30;
  localparam int          N_PHASES    = 6;
  localparam int          PHASE_CHARS = 41;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;

  // one keying segment as seen on the result ports
  typedef struct packed {
    logic        tone;
    logic [13:0] dur;
    logic        last;
  } segment_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [13:0] cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  char_code = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        tone_on;
  logic [13:0] duration_ms;
  logic        last;

  // bench state
  logic [7:0]  pending_chars [$];
  segment_t    seg_expect_q [$];
  logic [7:0]  directed_chars [0:24];
  string       known_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?/=";
  logic        steady = 1'b0;
  int          idle_cycles = 0;
  int          faults = 0;
  int          n_chars = 0;
  int          n_segments = 0;
  int          n_spaces = 0;
  int          n_unknown = 0;
  int          n_settings = 0;

  // encoder copy of the registers and the word-space flag
  int unsigned dot_len = 100;
  int unsigned dash_len = 300;
  int unsigned pause_len = 300;
  logic        word_gap_sent = 1'b0;

  morse_character_keyer dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .char_code   (char_code),
    .empty       (empty),
    .pop         (pop),
    .tone_on     (tone_on),
    .duration_ms (duration_ms),
    .last        (last)
  );

  always #5 clk = ~clk;

  // dots and dashes for a byte, empty string when it has no Morse code
  function automatic string morse_elements(input logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    case (u)
      "A": return ".-";     "B": return "-...";   "C": return "-.-.";
      "D": return "-..";    "E": return ".";      "F": return "..-.";
      "G": return "--.";    "H": return "....";   "I": return "..";
      "J": return ".---";   "K": return "-.-";    "L": return ".-..";
      "M": return "--";     "N": return "-.";     "O": return "---";
      "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
      "S": return "...";    "T": return "-";      "U": return "..-";
      "V": return "...-";   "W": return ".--";    "X": return "-..-";
      "Y": return "-.--";   "Z": return "--..";
      "0": return "-----";  "1": return ".----";  "2": return "..---";
      "3": return "...--";  "4": return "....-";  "5": return ".....";
      "6": return "-....";  "7": return "--...";  "8": return "---..";
      "9": return "----.";
      ".": return ".-.-.-"; ",": return "--..--"; "?": return "..--..";
      "/": return "-..-.";  "=": return "-...-";
      default: return "";
    endcase
  endfunction

  // queue one expected segment, clamped to the 14-bit duration field
  task automatic add_segment(input logic tone, input int unsigned dur, input logic fin);
    segment_t s;
    s.tone = tone;
    s.dur  = (dur > mck_pkg::DUR_MAX) ? mck_pkg::DUR_MAX : dur[13:0];
    s.last = fin;
    seg_expect_q.push_back(s);
  endtask

  // expected segments for one transferred byte
  task automatic predict_segments(input logic [7:0] c);
    string els;
    int    i;
    if (c <= 8'h20 || c >= 8'h7F) begin
      // word space: the long gap only once per run of spaces
      n_spaces++;
      if (!word_gap_sent) add_segment(1'b0, dot_len + pause_len, 1'b0);
      word_gap_sent = 1'b1;
    end else begin
      els = morse_elements(c);
      for (i = 0; i < els.len(); i++) begin
        if (i > 0) add_segment(1'b0, dot_len, 1'b0);
        add_segment(1'b1, (els[i] == "-") ? dash_len : dot_len, 1'b0);
      end
      if (els.len() > 0) word_gap_sent = 1'b0;
      else n_unknown++;
    end
    // closing character pause ends every byte
    add_segment(1'b0, pause_len, 1'b1);
  endtask

  task automatic log_fault(input string msg);
    faults++;
    if (faults <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // register write; called only while the keyer is idle
  task automatic write_reg(input logic [1:0] idx, input logic [13:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      mck_pkg::REG_DOT_MS:        dot_len   = {21'd0, data[10:0]};
      mck_pkg::REG_DASH_MS:       dash_len  = {20'd0, data[11:0]};
      mck_pkg::REG_CHAR_PAUSE_MS: pause_len = {18'd0, data};
      default: ;
    endcase
    n_settings++;
  endtask

  // wait for every byte to transfer and every segment to return
  task automatic drain_keyer();
    while (pending_chars.size() != 0 || seg_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // mostly Morse text with spaces, plus arbitrary bytes
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      c = known_chars[$urandom_range(0, known_chars.len() - 1)];
      if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) c = c + 8'd32;
    end else if (r < 80) begin
      case ($urandom_range(0, 3))
        0: c = 8'($urandom_range(0, 31));
        1: c = 8'($urandom_range(127, 255));
        default: c = 8'h20;
      endcase
    end else begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  // driver: feeds pending bytes, holds the item while full is high
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (push && full) begin
      // transfer blocked, keep item on the port
    end else begin
      if (push) begin
        predict_segments(char_code);
        n_chars++;
        pending_chars.delete(0);
      end
      if (pending_chars.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
        push      <= 1'b1;
        char_code <= pending_chars[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor: checks each popped segment against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_segments++;
        if (seg_expect_q.size() == 0) begin
          log_fault($sformatf("unexpected segment tone=%0b dur=%0d last=%0b",
                              tone_on, duration_ms, last));
        end else begin
          if ({tone_on, duration_ms, last} !== seg_expect_q[0]) begin
            log_fault($sformatf(
                "segment exp tone=%0b dur=%0d last=%0b, got tone=%0b dur=%0d last=%0b",
                seg_expect_q[0].tone, seg_expect_q[0].dur,
                seg_expect_q[0].last, tone_on, duration_ms, last));
          end
          seg_expect_q.delete(0);
        end
      end
      pop <= steady || ($urandom_range(0, 99) >= 25);
    end
  end

  // cycles since the last transfer on either side
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // watchdog
  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("tb_morse_character_keyer NOT OK");
    $finish;
  end

  // main sequence
  initial begin
    int p;
    int i;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed bytes at reset settings: spaces, unknowns, case folding, all marks
    directed_chars = '{8'h20, 8'h20, 8'h00, "!", 8'h1F, "E", 8'hFF, 8'h7F, "A", "a",
                       "z", "Z", "0", "5", "9", ".", ",", "?", "/", "=",
                       "~", "@", 8'h80, "T", 8'h20};
    for (i = 0; i < 25; i++) pending_chars.push_back(directed_chars[i]);
    drain_keyer();

    for (p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin
          write_reg(mck_pkg::REG_DOT_MS, 14'd1);
          write_reg(mck_pkg::REG_DASH_MS, 14'd1);
          write_reg(mck_pkg::REG_CHAR_PAUSE_MS, 14'd0);
        end
        1: begin
          write_reg(mck_pkg::REG_DOT_MS, 14'd1200);
          write_reg(mck_pkg::REG_DASH_MS, 14'd3600);
          write_reg(mck_pkg::REG_CHAR_PAUSE_MS, 14'd10000);
        end
        2: begin
          // all ones: word gap saturates
          write_reg(mck_pkg::REG_DOT_MS, 14'h3FFF);
          write_reg(mck_pkg::REG_DASH_MS, 14'h3FFF);
          write_reg(mck_pkg::REG_CHAR_PAUSE_MS, 14'h3FFF);
        end
        3: begin
          write_reg(mck_pkg::REG_DOT_MS, 14'($urandom_range(1, 1200)));
          write_reg(mck_pkg::REG_DASH_MS, 14'($urandom_range(1, 3600)));
          write_reg(mck_pkg::REG_CHAR_PAUSE_MS, 14'($urandom_range(0, 10000)));
        end
        4: begin
          // upper bits only: dot and dash truncate to zero
          write_reg(mck_pkg::REG_DOT_MS, 14'h3800);
          write_reg(mck_pkg::REG_DASH_MS, 14'h3000);
          write_reg(mck_pkg::REG_CHAR_PAUSE_MS, 14'($urandom_range(0, 16383)));
          write_reg(REG_UNUSED, 14'($urandom_range(0, 16383)));
        end
        default: begin
          write_reg(mck_pkg::REG_DOT_MS, 14'($urandom_range(0, 16383)));
          write_reg(mck_pkg::REG_DASH_MS, 14'($urandom_range(0, 16383)));
          write_reg(mck_pkg::REG_CHAR_PAUSE_MS, 14'($urandom_range(0, 16383)));
        end
      endcase
      steady <= (p == 2);
      for (i = 0; i < PHASE_CHARS; i++) begin
        // in phase 3 the sender holds off mid-phase until the keyer has gone quiet
        if (i == PHASE_CHARS / 2 && p == 3) drain_keyer();
        pending_chars.push_back(pick_char());
      end
      drain_keyer();
    end

    if (seg_expect_q.size() != 0)
      log_fault($sformatf("%0d segments never arrived", seg_expect_q.size()));
    $display("Covered %0d bytes (%0d word-space, %0d without code), %0d segments checked",
             n_chars, n_spaces, n_unknown, n_segments);
    $display("across %0d register writes, from zero-length to saturating durations",
             n_settings);
    if (faults == 0) begin
      $display("tb_morse_character_keyer OK");
    end else begin
      $display("%0d mismatches", faults);
      $display("tb_morse_character_keyer NOT OK");
    end
    $finish;
  end

endmodule
